[src/fp16as_pkg.sv]
// ----------------------------------------------------------------------------
// fp16as_pkg
// Shared types and constants for the half-precision add/subtract pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fp16as_pkg;

    localparam int FRAC_W = 10;
    localparam int EXP_W  = 5;
    localparam int SIG_W  = 15;   // hidden + 10 fraction + 4 extra bits
    localparam logic [EXP_W-1:0] EXP_ALL = 5'd31;
    localparam logic [15:0] CANON_NAN = 16'h7E00;

    localparam logic [1:0] RM_RNE = 2'd0;
    localparam logic [1:0] RM_RTZ = 2'd1;
    localparam logic [1:0] RM_RDN = 2'd2;
    localparam logic [1:0] RM_RUP = 2'd3;

    localparam int FL_NX = 0;
    localparam int FL_UF = 1;
    localparam int FL_OF = 2;
    localparam int FL_NV = 3;

    // path after the special-case decode
    localparam logic [1:0] PATH_SPECIAL = 2'd0;  // result fully known
    localparam logic [1:0] PATH_ADD     = 2'd1;
    localparam logic [1:0] PATH_SUB     = 2'd2;

    // stage 1 -> stage 2: aligned operands
    typedef struct packed {
        logic [1:0]       path;
        logic [15:0]      spec_res;
        logic [3:0]       spec_fl;
        logic [1:0]       rm;
        logic             sa;
        logic             sb;
        logic [EXP_W-1:0] e;
        logic [SIG_W:0]   ma;
        logic [SIG_W:0]   mb;
    } align_t;

    // stage 2 -> stage 3: raw sum or difference, normalized
    typedef struct packed {
        logic [1:0]       path;
        logic [15:0]      spec_res;
        logic [3:0]       spec_fl;
        logic [1:0]       rm;
        logic             sgn;
        logic             zero;
        logic             sub_norm;
        logic [6:0]       e;
        logic [SIG_W:0]   sig;
    } norm_t;

    function automatic logic [15:0] pack16(input logic s, input logic [EXP_W-1:0] e,
                                           input logic [FRAC_W-1:0] f);
        return {s, e, f};
    endfunction

endpackage

`default_nettype wire

[src/fp16as_align.sv]
// ----------------------------------------------------------------------------
// fp16as_align
// Decode special operands, resolve sums of two subnormals exactly and align significands with a sticky right shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16as_align (
    input  wire logic                  operation,
    input  wire logic [15:0]           operand_a,
    input  wire logic [15:0]           operand_b,
    input  wire logic [1:0]            round_mode,
    output fp16as_pkg::align_t         align
);

    logic       sa, sb;
    logic [4:0] ea, eb;
    logic [9:0] fa, fb;
    logic       nan_a, nan_b, inf_a, inf_b;
    logic [15:0] ma_raw, mb_raw, ma_sh, mb_sh;
    logic [4:0]  diff_ab, diff_ba;
    logic [10:0] sub_sum;

    function automatic logic [15:0] jam(input logic [15:0] v, input logic [4:0] d);
        logic [15:0] shifted;
        logic [15:0] mask;
        begin
            if (d >= 5'd16) begin
                jam = {15'd0, |v};
            end else begin
                shifted = v >> d;
                mask = ~(16'hFFFF << d);
                jam = shifted | {15'd0, |(v & mask)};
            end
        end
    endfunction

    always_comb begin
        sa = operand_a[15];
        sb = operand_b[15] ^ operation;
        ea = operand_a[14:10];
        eb = operand_b[14:10];
        fa = operand_a[9:0];
        fb = operand_b[9:0];
        nan_a = (ea == fp16as_pkg::EXP_ALL) && (fa != 10'd0);
        nan_b = (eb == fp16as_pkg::EXP_ALL) && (fb != 10'd0);
        inf_a = (ea == fp16as_pkg::EXP_ALL) && (fa == 10'd0);
        inf_b = (eb == fp16as_pkg::EXP_ALL) && (fb == 10'd0);

        ma_raw = {1'b0, ((ea != 5'd0) ? {1'b1, fa} : {fa, 1'b0}), 4'd0};
        mb_raw = {1'b0, ((eb != 5'd0) ? {1'b1, fb} : {fb, 1'b0}), 4'd0};
        diff_ab = ea - eb;
        diff_ba = eb - ea;
        ma_sh = (eb > ea) ? jam(ma_raw, diff_ba) : ma_raw;
        mb_sh = (ea > eb) ? jam(mb_raw, diff_ab) : mb_raw;
        sub_sum = {1'b0, fa} + {1'b0, fb};

        align.rm = round_mode;
        align.sa = sa;
        align.sb = sb;
        align.e = (ea > eb) ? ea : eb;
        align.ma = ma_sh;
        align.mb = mb_sh;
        align.spec_fl = 4'd0;
        align.spec_res = 16'd0;
        align.path = (sa == sb) ? fp16as_pkg::PATH_ADD : fp16as_pkg::PATH_SUB;

        if (nan_a || nan_b) begin
            align.path = fp16as_pkg::PATH_SPECIAL;
            align.spec_res = fp16as_pkg::CANON_NAN;
            align.spec_fl[fp16as_pkg::FL_NV] = (nan_a && !fa[9]) || (nan_b && !fb[9]);
        end else if (inf_a || inf_b) begin
            align.path = fp16as_pkg::PATH_SPECIAL;
            if (inf_a && inf_b && (sa != sb)) begin
                align.spec_res = fp16as_pkg::CANON_NAN;
                align.spec_fl[fp16as_pkg::FL_NV] = 1'b1;
            end else if (inf_a) begin
                align.spec_res = fp16as_pkg::pack16(sa, fp16as_pkg::EXP_ALL, 10'd0);
            end else begin
                align.spec_res = fp16as_pkg::pack16(sb, fp16as_pkg::EXP_ALL, 10'd0);
            end
        end else if (ea == 5'd0 && eb == 5'd0) begin
            align.path = fp16as_pkg::PATH_SPECIAL;
            if (sa == sb) begin
                align.spec_res = {sa, 4'd0, sub_sum};
            end else if (fa == fb) begin
                align.spec_res = fp16as_pkg::pack16(round_mode == fp16as_pkg::RM_RDN,
                                                    5'd0, 10'd0);
            end else if (fa > fb) begin
                align.spec_res = fp16as_pkg::pack16(sa, 5'd0, fa - fb);
            end else begin
                align.spec_res = fp16as_pkg::pack16(sb, 5'd0, fb - fa);
            end
        end
    end

endmodule

`default_nettype wire

[src/fp16as_norm.sv]
// ----------------------------------------------------------------------------
// fp16as_norm
// Add or subtract the aligned significands and normalize the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16as_norm (
    input  wire fp16as_pkg::align_t align,
    output fp16as_pkg::norm_t       norm
);

    logic [15:0] sum, diff, shifted;
    logic [3:0]  lz;
    logic [6:0]  e_ext;
    logic [6:0]  need;
    logic        a_ge;

    always_comb begin
        e_ext = {2'd0, align.e};
        sum = align.ma + align.mb;
        a_ge = align.ma >= align.mb;
        diff = a_ge ? (align.ma - align.mb) : (align.mb - align.ma);

        // count leading zeros below bit 14 (diff fits in 15 bits)
        lz = 4'd14;
        for (int i = 0; i < 15; i++) begin
            if (diff[i]) begin
                lz = 4'(14 - i);
            end
        end
        need = {3'd0, lz};

        norm.path = align.path;
        norm.spec_res = align.spec_res;
        norm.spec_fl = align.spec_fl;
        norm.rm = align.rm;
        norm.zero = 1'b0;
        norm.sub_norm = 1'b0;
        norm.sgn = align.sa;
        norm.e = e_ext;
        norm.sig = sum;
        shifted = 16'd0;

        if (align.path == fp16as_pkg::PATH_ADD) begin
            if (sum[15]) begin
                norm.sig = {1'b0, sum[15:2], |sum[1:0]};
                norm.e = e_ext + 7'd1;
            end
        end else if (align.path == fp16as_pkg::PATH_SUB) begin
            norm.sgn = a_ge ? align.sa : align.sb;
            norm.zero = (diff == 16'd0);
            if (need > e_ext - 7'd1) begin
                norm.sub_norm = 1'b1;
                shifted = diff << (e_ext - 7'd1);
                norm.sig = shifted;
                norm.e = 7'd0;
            end else begin
                norm.sig = diff << need;
                norm.e = e_ext - need;
            end
        end
    end

endmodule

`default_nettype wire

[src/fp16as_round.sv]
// ----------------------------------------------------------------------------
// fp16as_round
// Round the normalized significand, pack the result and build the flags.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16as_round (
    input  wire fp16as_pkg::norm_t norm,
    output logic [15:0]            result,
    output logic [3:0]             flags
);

    logic [3:0]  rb;
    logic        inc;
    logic [15:0] sig_r;
    logic [6:0]  e_r;

    always_comb begin
        rb = norm.sig[3:0];
        unique case (norm.rm)
            fp16as_pkg::RM_RNE: inc = (rb > 4'h8) || (rb == 4'h8 && norm.sig[4]);
            fp16as_pkg::RM_RTZ: inc = 1'b0;
            fp16as_pkg::RM_RDN: inc = norm.sgn && (rb != 4'h0);
            fp16as_pkg::RM_RUP: inc = !norm.sgn && (rb != 4'h0);
            default:            inc = 1'b0;
        endcase
        sig_r = norm.sig;
        e_r = norm.e;
        if (inc) begin
            sig_r = norm.sig + 16'h10;
            if (sig_r[15]) begin
                sig_r = {1'b0, sig_r[15:2], |sig_r[1:0]};
                e_r = norm.e + 7'd1;
            end
        end

        flags = 4'd0;
        if (norm.path == fp16as_pkg::PATH_SPECIAL) begin
            result = norm.spec_res;
            flags = norm.spec_fl;
        end else if (norm.zero) begin
            result = fp16as_pkg::pack16(norm.rm == fp16as_pkg::RM_RDN, 5'd0, 10'd0);
        end else if (norm.sub_norm) begin
            result = fp16as_pkg::pack16(norm.sgn, 5'd0, norm.sig[13:4]);
            flags[fp16as_pkg::FL_UF] = 1'b1;
            flags[fp16as_pkg::FL_NX] = (rb != 4'h0);
        end else if (e_r >= 7'd31) begin
            result = fp16as_pkg::pack16(norm.sgn, fp16as_pkg::EXP_ALL, 10'd0);
            flags[fp16as_pkg::FL_OF] = 1'b1;
            flags[fp16as_pkg::FL_NX] = 1'b1;
        end else begin
            result = fp16as_pkg::pack16(norm.sgn, e_r[4:0], sig_r[13:4]);
            flags[fp16as_pkg::FL_NX] = (rb != 4'h0);
        end
    end

endmodule

`default_nettype wire

[src/fp16_add_sub_unit.sv]
// ----------------------------------------------------------------------------
// fp16_add_sub_unit
// Half-precision adder/subtractor, three register stages.
// ----------------------------------------------------------------------------
// Usage:
//   input channel s_*: operation (0 add, 1 a-b), operand_a, operand_b,
//   round_mode; one item accepted when s_valid and s_ready are high.
//   result channel m_*: result and flags (inexact, underflow, overflow,
//   invalid), one per input item, in order.
// Path: an accepted item is registered in align_reg, then norm_reg, then
//   result_reg; m_valid rises when it reaches result_reg.
// Throughput: one item per cycle while m_ready stays high; set by the
//   three-stage pipeline (align, add/normalize, round/pack).
// Stalls: while m_ready is low the pipeline advances only into empty stages;
//   s_ready drops once every stage holds an item. Nothing is lost or repeated.
// Reset: aresetn low clears all valid bits; the pipeline comes up empty and
//   ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16_add_sub_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [15:0] s_operand_a,
    input  wire logic [15:0] s_operand_b,
    input  wire logic [1:0]  s_round_mode,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_result,
    output logic [3:0]       m_flags
);

    fp16as_pkg::align_t align_next, align_reg;
    fp16as_pkg::norm_t  norm_next, norm_reg;
    logic [15:0] result_next, result_reg;
    logic [3:0]  flags_next, flags_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    fp16as_align u_align (
        .operation  (s_operation),
        .operand_a  (s_operand_a),
        .operand_b  (s_operand_b),
        .round_mode (s_round_mode),
        .align      (align_next)
    );

    fp16as_norm u_norm (
        .align (align_reg),
        .norm  (norm_next)
    );

    fp16as_round u_round (
        .norm   (norm_reg),
        .result (result_next),
        .flags  (flags_next)
    );

    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) align_reg <= align_next;
        if (adv2) norm_reg <= norm_next;
        if (adv3) begin
            result_reg <= result_next;
            flags_reg <= flags_next;
        end
    end

    assign m_valid = v3_reg;
    assign m_result = result_reg;
    assign m_flags = flags_reg;

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result) && $stable(m_flags))
        else $error("stalled result changed");

    // input blocked only when the whole pipeline is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && !m_ready)
        else $error("input blocked with a free stage");

    // a stage that could not advance keeps its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv2 |=> v2_reg)
        else $error("stage two item lost");

    // overflow always comes with inexact
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flags[fp16as_pkg::FL_OF] |-> m_flags[fp16as_pkg::FL_NX])
        else $error("overflow without inexact");

endmodule

`default_nettype wire

[tb/tb_fp16_add_sub_unit.sv]
// ----------------------------------------------------------------------------
// tb_fp16_add_sub_unit
// Self-checking bench for the half-precision adder/subtractor: a directed
// stimulus table, then random items under several handshake idling phases,
// each result checked against an in-bench arithmetic predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fp16_add_sub_unit;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;
    localparam logic [3:0] FLAGS_NONE = 4'h0;
    localparam logic [3:0] FLAGS_NV   = 4'h8;
    localparam logic [3:0] FLAGS_OVF  = 4'h5;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        op;
        logic [15:0] a;
        logic [15:0] b;
        logic [1:0]  rm;
        logic        known;
        logic [15:0] res;
        logic [3:0]  fl;
    } vec_t;

    typedef struct packed {
        logic [15:0] res;
        logic [3:0]  fl;
    } sum_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic [15:0] s_operand_a = '0;
    logic [15:0] s_operand_b = '0;
    logic [1:0]  s_round_mode = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result;
    logic [3:0]  m_flags;

    sum_t expected_sums[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_recv = 1'b0;

    always #6 aclk = ~aclk;

    fp16_add_sub_unit i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation, .s_operand_a,
        .s_operand_b, .s_round_mode, .m_valid, .m_ready, .m_result, .m_flags
    );

    function automatic logic [31:0] sticky_shift(logic [31:0] v, logic [31:0] d);
        if (d >= 31) return (v != 0) ? 32'd1 : 32'd0;
        return (v >> d) | ((v & ((32'd1 << d) - 1)) != 0 ? 32'd1 : 32'd0);
    endfunction

    function automatic sum_t round_out(logic s, int e, logic [31:0] sig, logic [1:0] rm);
        sum_t r;
        logic [3:0] rb;
        logic inc;
        rb = sig[3:0];
        r.fl = FLAGS_NONE;
        case (rm)
            fp16as_pkg::RM_RNE: inc = (rb > 4'h8) || (rb == 4'h8 && sig[4]);
            fp16as_pkg::RM_RDN: inc = s && rb != 0;
            fp16as_pkg::RM_RUP: inc = !s && rb != 0;
            default: inc = 1'b0;
        endcase
        if (inc) begin
            sig = sig + 32'h10;
            if (sig[fp16as_pkg::SIG_W]) begin
                sig = sticky_shift(sig, 1);
                e++;
            end
        end
        if (e >= 31) begin
            r.res = fp16as_pkg::pack16(s, fp16as_pkg::EXP_ALL, '0);
            r.fl = FLAGS_OVF;
            return r;
        end
        if (rb != 0) r.fl[fp16as_pkg::FL_NX] = 1'b1;
        r.res = {s, e[4:0], sig[13:4]};
        return r;
    endfunction

    function automatic sum_t fp16_sum(logic op, logic [15:0] a, logic [15:0] b,
                                      logic [1:0] rm);
        sum_t r;
        logic sa, sb, sgn, nan_a, nan_b;
        logic [4:0] ea, eb;
        logic [9:0] fa, fb;
        logic [31:0] ma, mb, acc, sh;
        int e, hb, need;
        sa = a[15]; sb = b[15] ^ op;
        ea = a[14:10]; eb = b[14:10];
        fa = a[9:0]; fb = b[9:0];
        r.fl = FLAGS_NONE;
        nan_a = ea == fp16as_pkg::EXP_ALL && fa != 0;
        nan_b = eb == fp16as_pkg::EXP_ALL && fb != 0;
        if (nan_a || nan_b) begin
            r.res = fp16as_pkg::CANON_NAN;
            if ((nan_a && !fa[9]) || (nan_b && !fb[9])) r.fl[fp16as_pkg::FL_NV] = 1'b1;
        end else if (ea == fp16as_pkg::EXP_ALL || eb == fp16as_pkg::EXP_ALL) begin
            if (ea == fp16as_pkg::EXP_ALL && eb == fp16as_pkg::EXP_ALL && sa != sb) begin
                r.res = fp16as_pkg::CANON_NAN;
                r.fl = FLAGS_NV;
            end else if (ea == fp16as_pkg::EXP_ALL) begin
                r.res = fp16as_pkg::pack16(sa, fp16as_pkg::EXP_ALL, '0);
            end else begin
                r.res = fp16as_pkg::pack16(sb, fp16as_pkg::EXP_ALL, '0);
            end
        end else if (ea == 0 && eb == 0) begin
            // both subnormal: exact, may carry into the smallest normal
            if (sa == sb) r.res = {sa, 15'd0} + fa + fb;
            else if (fa == fb) r.res = fp16as_pkg::pack16(rm == fp16as_pkg::RM_RDN, '0, '0);
            else if (fa > fb) r.res = fp16as_pkg::pack16(sa, '0, fa - fb);
            else r.res = fp16as_pkg::pack16(sb, '0, fb - fa);
        end else begin
            ma = (ea != 0 ? {21'd0, 1'b1, fa} : {21'd0, fa, 1'b0}) << 4;
            mb = (eb != 0 ? {21'd0, 1'b1, fb} : {21'd0, fb, 1'b0}) << 4;
            e = (ea > eb) ? ea : eb;
            if (ea > eb) mb = sticky_shift(mb, ea - eb);
            else if (eb > ea) ma = sticky_shift(ma, eb - ea);
            if (sa == sb) begin
                acc = ma + mb;
                if (acc[fp16as_pkg::SIG_W]) begin
                    acc = sticky_shift(acc, 1);
                    e++;
                end
                r = round_out(sa, e, acc, rm);
            end else begin
                if (ma >= mb) begin acc = ma - mb; sgn = sa; end
                else begin acc = mb - ma; sgn = sb; end
                if (acc == 0) r.res = fp16as_pkg::pack16(rm == fp16as_pkg::RM_RDN, '0, '0);
                else begin
                    hb = 0;
                    for (int i = 0; i < 32; i++) if (acc[i]) hb = i;
                    need = fp16as_pkg::FRAC_W + 4 - hb;
                    if (need > e - 1) begin
                        // too small to normalize: truncate into a subnormal
                        sh = acc << (e - 1);
                        r.fl[fp16as_pkg::FL_UF] = 1'b1;
                        if (sh[3:0] != 0) r.fl[fp16as_pkg::FL_NX] = 1'b1;
                        r.res = {sgn, 5'd0, sh[13:4]};
                    end else r = round_out(sgn, e - need, acc << need, rm);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(vec_t v);
        sum_t want;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        want = v.known ? sum_t'{v.res, v.fl} : fp16_sum(v.op, v.a, v.b, v.rm);
        if (v.known && fp16_sum(v.op, v.a, v.b, v.rm) != want)
            report_mismatch("table row", fp16_sum(v.op, v.a, v.b, v.rm).res, want.res);
        s_valid      <= 1'b1;
        s_operation  <= v.op;
        s_operand_a  <= v.a;
        s_operand_b  <= v.b;
        s_round_mode <= v.rm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_sums.push_back(want);
    endtask

    function automatic logic [15:0] pick_operand();
        logic [15:0] x;
        x = 16'($urandom);
        case ($urandom_range(9))
            0: x[14:10] = fp16as_pkg::EXP_ALL;
            1: x[14:10] = 5'd0;
            2: x[14:10] = 5'd30;
            default: ;
        endcase
        return x;
    endfunction

    // receiver with stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_recv &&
            (recv_stall_pct == 0 || $urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        sum_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected result", m_result, 16'd0);
            end else begin
                want = expected_sums.pop_front();
                if (m_result !== want.res) report_mismatch("result", m_result, want.res);
                if (m_flags !== want.fl) report_mismatch("flags", {12'd0, m_flags},
                                                         {12'd0, want.fl});
            end
        end
    end

    vec_t stim_table[] = '{
        '{OP_ADD, 16'h0000, 16'h0000, fp16as_pkg::RM_RNE, 1'b1, 16'h0000, FLAGS_NONE},
        '{OP_SUB, 16'h3C00, 16'h3C00, fp16as_pkg::RM_RDN, 1'b1, 16'h8000, FLAGS_NONE},
        '{OP_SUB, 16'h3C00, 16'h3C00, fp16as_pkg::RM_RNE, 1'b1, 16'h0000, FLAGS_NONE},
        '{OP_ADD, 16'h7E00, 16'h3C00, fp16as_pkg::RM_RNE, 1'b1, fp16as_pkg::CANON_NAN,
          FLAGS_NONE},
        '{OP_ADD, 16'h7C01, 16'h3C00, fp16as_pkg::RM_RTZ, 1'b1, fp16as_pkg::CANON_NAN,
          FLAGS_NV},
        '{OP_ADD, 16'h3C00, 16'hFDFF, fp16as_pkg::RM_RUP, 1'b1, fp16as_pkg::CANON_NAN,
          FLAGS_NV},
        '{OP_ADD, 16'h7C00, 16'hFC00, fp16as_pkg::RM_RNE, 1'b1, fp16as_pkg::CANON_NAN,
          FLAGS_NV},
        '{OP_SUB, 16'h7C00, 16'h7C00, fp16as_pkg::RM_RNE, 1'b1, fp16as_pkg::CANON_NAN,
          FLAGS_NV},
        '{OP_SUB, 16'h3C00, 16'h7C00, fp16as_pkg::RM_RNE, 1'b1, 16'hFC00, FLAGS_NONE},
        '{OP_ADD, 16'h7BFF, 16'h7BFF, fp16as_pkg::RM_RTZ, 1'b1, 16'h7C00, FLAGS_OVF},
        '{OP_ADD, 16'hFBFF, 16'hFBFF, fp16as_pkg::RM_RUP, 1'b1, 16'hFC00, FLAGS_OVF},
        '{OP_ADD, 16'h0001, 16'h03FF, fp16as_pkg::RM_RNE, 1'b1, 16'h0400, FLAGS_NONE},
        '{OP_SUB, 16'h0001, 16'h0003, fp16as_pkg::RM_RNE, 1'b1, 16'h8002, FLAGS_NONE},
        '{OP_SUB, 16'h0401, 16'h0400, fp16as_pkg::RM_RNE, 1'b0, '0, '0},
        '{OP_SUB, 16'h0800, 16'h07FF, fp16as_pkg::RM_RTZ, 1'b0, '0, '0},
        '{OP_ADD, 16'h3C00, 16'h0001, fp16as_pkg::RM_RUP, 1'b0, '0, '0},
        '{OP_ADD, 16'h3C00, 16'h0001, fp16as_pkg::RM_RNE, 1'b0, '0, '0},
        '{OP_SUB, 16'h3C00, 16'h0001, fp16as_pkg::RM_RDN, 1'b0, '0, '0},
        '{OP_ADD, 16'h3C01, 16'h1000, fp16as_pkg::RM_RNE, 1'b0, '0, '0},
        '{OP_SUB, 16'h0400, 16'hC000, fp16as_pkg::RM_RTZ, 1'b0, '0, '0},
        '{OP_ADD, 16'h3C00, 16'hC400, fp16as_pkg::RM_RUP, 1'b0, '0, '0},
        '{OP_SUB, 16'hFFFF, 16'hFFFF, fp16as_pkg::RM_RDN, 1'b0, '0, '0},
        '{OP_ADD, 16'h8400, 16'h0401, fp16as_pkg::RM_RNE, 1'b0, '0, '0}
    };

    initial begin
        vec_t v;
        int hold_cycles;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (stim_table[i]) send_item(stim_table[i]);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 36 : 0;
            for (int n = 0; n < 200; n++) begin
                if (phase == 2 && n == 100) begin
                    // drain fully before the next burst
                    s_valid <= 1'b0;
                    while (expected_sums.size() != 0) @(posedge aclk);
                end
                if (phase == 0 && n == 50) begin
                    hold_recv = 1'b1;
                    fork
                        begin
                            for (hold_cycles = 0; hold_cycles < 40; hold_cycles++)
                                @(posedge aclk);
                            hold_recv = 1'b0;
                        end
                    join_none
                end
                v.op = 1'($urandom);
                v.a = pick_operand();
                v.b = pick_operand();
                if ($urandom_range(3) == 0)
                    v.b[14:10] = v.a[14:10] + 5'($urandom_range(2)) - 5'd1;
                v.rm = 2'($urandom);
                v.known = 1'b0;
                v.res = '0;
                v.fl = '0;
                send_item(v);
            end
        end

        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/fp16as_pkg.sv
src/fp16as_align.sv
src/fp16as_norm.sv
src/fp16as_round.sv
src/fp16_add_sub_unit.sv
tb/tb_fp16_add_sub_unit.sv
